// File: hdl/rttco_pkg.sv
// Shared constants and types of the round trip and clock offset estimator.
`default_nettype none

package rttco_pkg;

   localparam int unsigned TIME_BITS_DEF = 48;

   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 24;
   localparam int unsigned WEIGHT_BITS    = 9;
   localparam int unsigned COUNT_BITS     = 8;
   localparam int unsigned CONF_BITS      = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RTT_WEIGHT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEV_WEIGHT = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_COUNT = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_CONF  = 8'd3;

   localparam logic [WEIGHT_BITS-1:0] RTT_WEIGHT_RST = 9'd8;
   localparam logic [WEIGHT_BITS-1:0] DEV_WEIGHT_RST = 9'd4;
   localparam logic [COUNT_BITS-1:0]  INIT_COUNT_RST = 8'd5;
   localparam logic [CONF_BITS-1:0]   INIT_CONF_RST  = 24'd100000;
   localparam logic [COUNT_BITS-1:0]  REPLY_COUNT_MAX = 8'd255;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREP = 6'b000010,
      ST_PLAN = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [4:0] {
      PH_DEV  = 5'b00001,
      PH_RTT  = 5'b00010,
      PH_OFFA = 5'b00100,
      PH_OFFB = 5'b01000,
      PH_CONF = 5'b10000
   } phase_type;

endpackage

`default_nettype wire

// File: hdl/rttco_chan_if.sv
// Request and response channel interfaces of the estimator.
`default_nettype none

interface rttco_req_if #(
   parameter int unsigned TIME_BITS = rttco_pkg::TIME_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic                 has_sync;
   logic                 has_end;
   logic                 has_reply;
   logic [TIME_BITS-1:0] sync_time;
   logic [TIME_BITS-1:0] echoed_time;
   logic [TIME_BITS-1:0] arrival_time;

   modport source (
      output valid, has_sync, has_end, has_reply, sync_time, echoed_time, arrival_time,
      input  ready
   );
   modport sink (
      input  valid, has_sync, has_end, has_reply, sync_time, echoed_time, arrival_time,
      output ready
   );
endinterface

interface rttco_rsp_if #(
   parameter int unsigned TIME_BITS = rttco_pkg::TIME_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic                        send_reply;
   logic                        reply_with_sync;
   logic [TIME_BITS-1:0]        reply_echo_time;
   logic signed [TIME_BITS+1:0] arrival_delay;
   logic signed [TIME_BITS:0]   rtt_estimate;
   logic [TIME_BITS-1:0]        rtt_deviation;
   logic                        connect_event;

   modport source (
      output valid, send_reply, reply_with_sync, reply_echo_time, arrival_delay,
             rtt_estimate, rtt_deviation, connect_event,
      input  ready
   );
   modport sink (
      input  valid, send_reply, reply_with_sync, reply_echo_time, arrival_delay,
             rtt_estimate, rtt_deviation, connect_event,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/rtt_and_clock_offset_estimator.sv
// Round trip estimator: exponential smoothing plus confidence-weighted clock offset.
// Each request is one received header with its local arrival time; each gives exactly
// one response. A request is taken only while the block is idle. A header without the
// reply flag, or the first reply, goes from acceptance through the PREP, PLAN and OUT
// states to its response. Later replies run on one shared shift-add multiplier and one
// restoring divider (one bit a cycle) under a small sequencer: two weighted means, each
// a multiply then a divide, then the offset (two multiplies and a divide) and the
// confidence (a multiply and a divide); an empty denominator skips the last two.
// The response register lets a finished result wait while a new request is taken.
`default_nettype none

module rtt_and_clock_offset_estimator #(
   parameter int unsigned TIME_BITS = rttco_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   rttco_req_if.sink                           req_chan,
   rttco_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_en,
   input  logic [rttco_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rttco_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import rttco_pkg::*;

   localparam int unsigned TB   = TIME_BITS;
   localparam int unsigned OB   = TB + 1;
   localparam int unsigned DB   = TB + 2;
   localparam int unsigned AB   = 2 * TB + 2;
   localparam int unsigned WNB  = TB + WEIGHT_BITS + 1;
   localparam int unsigned CNTB = $clog2(AB + 1);

   localparam logic signed [OB-1:0] OFF_MAX = {1'b0, {TB{1'b1}}};
   localparam logic signed [OB-1:0] OFF_MIN = {1'b1, {TB{1'b0}}};

   // configuration
   logic [WEIGHT_BITS-1:0] rtt_w_ff, rtt_w_in, dev_w_ff, dev_w_in;
   logic [COUNT_BITS-1:0]  init_cnt_ff, init_cnt_in;

   // estimator state
   logic signed [OB-1:0] rtt_ff, rtt_in, off_ff, off_in;
   logic [TB-1:0]        dev_ff, dev_in, conf_ff, conf_in;
   logic                 seeded_ff, seeded_in, reported_ff, reported_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // current request
   logic          sync_ff, sync_in, end_ff, end_in, reply_ff, reply_in;
   logic [TB-1:0] sync_time_ff, sync_time_in, now_ff, now_in, s_ff, s_in;

   // work registers
   logic [TB-1:0]        diff_ff, diff_in;
   logic signed [OB-1:0] nd_ff, nd_in;
   logic [OB-1:0]        den_ff, den_in, divr_ff, divr_in, rem_ff, rem_in;
   logic [AB-1:0]        acc_ff, acc_in, mcand_ff, mcand_in;
   logic [TB-1:0]        mq_ff, mq_in;
   logic [CNTB-1:0]      step_ff, step_in;
   logic                 neg_ff, neg_in;
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;

   // response register
   logic                 rv_ff, rv_in;
   logic                 o_send_ff, o_send_in, o_wsync_ff, o_wsync_in, o_event_ff, o_event_in;
   logic [TB-1:0]        o_echo_ff, o_echo_in, o_dev_ff, o_dev_in;
   logic signed [DB-1:0] o_delay_ff, o_delay_in;
   logic signed [OB-1:0] o_rtt_ff, o_rtt_in;

   // launch values for a multiply phase
   phase_type            lph;
   logic [AB-1:0]        l_acc, l_mcand;
   logic [TB-1:0]        l_mq;
   logic [CNTB-1:0]      l_steps;

   logic [WEIGHT_BITS-1:0] rtt_w_eff, dev_w_eff;
   logic                   accept;
   logic [TB:0]            s_wide;
   logic signed [OB-1:0]   d_sig;
   logic signed [DB-1:0]   nd_wide;
   logic [TB-1:0]          r_mag;
   logic [OB:0]            trial;
   logic                   ge;
   logic [AB-1:0]          neg_acc, pre_acc;
   logic [OB-1:0]          q_off;

   assign rtt_w_eff = (rtt_w_ff == '0) ? WEIGHT_BITS'(1) : rtt_w_ff;
   assign dev_w_eff = (dev_w_ff == '0) ? WEIGHT_BITS'(1) : dev_w_ff;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign s_wide = {1'b0, req_chan.arrival_time} - {1'b0, req_chan.echoed_time};

   assign d_sig   = $signed({1'b0, now_ff}) - $signed({1'b0, sync_time_ff});
   assign nd_wide = {d_sig[OB-1], d_sig} - $signed({2'b00, s_ff[TB-1:1]});
   assign r_mag   = rtt_ff[TB-1:0];

   assign trial   = {rem_ff, acc_ff[AB-1]};
   assign ge      = (trial >= {1'b0, divr_ff});
   assign neg_acc = (~acc_ff) + AB'(1);
   assign q_off   = neg_ff ? ((~acc_ff[OB-1:0]) + OB'(1)) : acc_ff[OB-1:0];

   always_comb begin
      unique case (lph)
         PH_DEV: begin
            l_acc   = {{(AB-TB){1'b0}}, diff_ff};
            l_mcand = {{(AB-TB){1'b0}}, dev_ff};
            l_mq    = {{(TB-WEIGHT_BITS){1'b0}}, dev_w_eff - WEIGHT_BITS'(1)};
            l_steps = CNTB'(WEIGHT_BITS);
         end
         PH_RTT: begin
            l_acc   = {{(AB-TB){1'b0}}, s_ff};
            l_mcand = {{(AB-TB){1'b0}}, r_mag};
            l_mq    = {{(TB-WEIGHT_BITS){1'b0}}, rtt_w_eff - WEIGHT_BITS'(1)};
            l_steps = CNTB'(WEIGHT_BITS);
         end
         PH_OFFA: begin
            l_acc   = '0;
            l_mcand = {{(AB-OB){nd_ff[OB-1]}}, nd_ff};
            l_mq    = conf_ff;
            l_steps = CNTB'(TB);
         end
         PH_OFFB: begin
            l_acc   = acc_ff;
            l_mcand = {{(AB-OB){off_ff[OB-1]}}, off_ff};
            l_mq    = s_ff;
            l_steps = CNTB'(TB);
         end
         PH_CONF: begin
            l_acc   = '0;
            l_mcand = {{(AB-OB){1'b0}}, conf_ff, 1'b0};
            l_mq    = s_ff;
            l_steps = CNTB'(TB);
         end
         default: begin
            l_acc   = '0;
            l_mcand = '0;
            l_mq    = '0;
            l_steps = '0;
         end
      endcase
   end

   // prepare the numerator for the divider: left-align a weighted mean, or take the offset's magnitude
   always_comb begin
      priority if (phase_ff == PH_OFFB) begin
         pre_acc = acc_ff[AB-1] ? neg_acc : acc_ff;
      end else if (phase_ff == PH_CONF) begin
         pre_acc = acc_ff;
      end else begin
         pre_acc = acc_ff << (AB - WNB);
      end
   end

   always_comb begin
      rtt_w_in     = rtt_w_ff;
      dev_w_in     = dev_w_ff;
      init_cnt_in  = init_cnt_ff;
      rtt_in       = rtt_ff;
      off_in       = off_ff;
      dev_in       = dev_ff;
      conf_in      = conf_ff;
      seeded_in    = seeded_ff;
      reported_in  = reported_ff;
      count_in     = count_ff;
      sync_in      = sync_ff;
      end_in       = end_ff;
      reply_in     = reply_ff;
      sync_time_in = sync_time_ff;
      now_in       = now_ff;
      s_in         = s_ff;
      diff_in      = diff_ff;
      nd_in        = nd_ff;
      den_in       = den_ff;
      divr_in      = divr_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mq_in        = mq_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      rv_in        = rv_ff;
      o_send_in    = o_send_ff;
      o_wsync_in   = o_wsync_ff;
      o_event_in   = o_event_ff;
      o_echo_in    = o_echo_ff;
      o_dev_in     = o_dev_ff;
      o_delay_in   = o_delay_ff;
      o_rtt_in     = o_rtt_ff;
      lph          = PH_DEV;

      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RTT_WEIGHT: rtt_w_in = csr_write_data[WEIGHT_BITS-1:0];
            CSR_DEV_WEIGHT: dev_w_in = csr_write_data[WEIGHT_BITS-1:0];
            CSR_INIT_COUNT: init_cnt_in = csr_write_data[COUNT_BITS-1:0];
            CSR_INIT_CONF: begin
               if (!seeded_ff) begin
                  conf_in = {{(TB-CONF_BITS){1'b0}}, csr_write_data[CONF_BITS-1:0]};
               end
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sync_in      = req_chan.has_sync;
               end_in       = req_chan.has_end;
               reply_in     = req_chan.has_reply;
               sync_time_in = req_chan.sync_time;
               now_in       = req_chan.arrival_time;
               s_in         = s_wide[TB] ? '0 : s_wide[TB-1:0];
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            diff_in = (r_mag >= s_ff) ? (r_mag - s_ff) : (s_ff - r_mag);
            den_in  = {1'b0, conf_ff} + {1'b0, s_ff};
            priority if (nd_wide < $signed({OFF_MIN[OB-1], OFF_MIN})) begin
               nd_in = OFF_MIN;
            end else if (nd_wide > $signed({1'b0, OFF_MAX})) begin
               nd_in = OFF_MAX;
            end else begin
               nd_in = nd_wide[OB-1:0];
            end
            if (reply_ff && (count_ff != REPLY_COUNT_MAX)) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            priority if (!reply_ff) begin
               state_in = ST_OUT;
            end else if (rtt_ff[OB-1] || !seeded_ff) begin
               // first reply seeds everything
               rtt_in    = $signed({1'b0, s_ff});
               dev_in    = s_ff;
               off_in    = nd_ff;
               conf_in   = s_ff;
               seeded_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               lph      = PH_DEV;
               phase_in = PH_DEV;
               acc_in   = l_acc;
               mcand_in = l_mcand;
               mq_in    = l_mq;
               step_in  = l_steps;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff != '0) begin
               acc_in   = mq_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
               mcand_in = mcand_ff << 1;
               mq_in    = mq_ff >> 1;
               step_in  = step_ff - CNTB'(1);
            end else if (phase_ff == PH_OFFA) begin
               lph      = PH_OFFB;
               phase_in = PH_OFFB;
               acc_in   = l_acc;
               mcand_in = l_mcand;
               mq_in    = l_mq;
               step_in  = l_steps;
            end else begin
               neg_in   = acc_ff[AB-1];
               acc_in   = pre_acc;
               rem_in   = '0;
               state_in = ST_DIV;
               priority if (phase_ff == PH_DEV) begin
                  divr_in = {{(OB-WEIGHT_BITS){1'b0}}, dev_w_eff};
                  step_in = CNTB'(WNB);
               end else if (phase_ff == PH_RTT) begin
                  divr_in = {{(OB-WEIGHT_BITS){1'b0}}, rtt_w_eff};
                  step_in = CNTB'(WNB);
               end else begin
                  divr_in = den_ff;
                  step_in = CNTB'(AB);
               end
            end
         end
         ST_DIV: begin
            if (step_ff != '0) begin
               rem_in  = ge ? (trial[OB-1:0] - divr_ff) : trial[OB-1:0];
               acc_in  = {acc_ff[AB-2:0], ge};
               step_in = step_ff - CNTB'(1);
            end else begin
               state_in = ST_MUL;
               unique case (phase_ff)
                  PH_DEV: begin
                     dev_in = acc_ff[TB-1:0];
                     lph    = PH_RTT;
                  end
                  PH_RTT: begin
                     rtt_in = $signed({1'b0, acc_ff[TB-1:0]});
                     lph    = PH_OFFA;
                     if (den_ff == '0) begin
                        // empty denominator: keep offset, zero confidence
                        conf_in  = '0;
                        state_in = ST_OUT;
                     end
                  end
                  PH_OFFB: begin
                     off_in = $signed(q_off);
                     lph    = PH_CONF;
                  end
                  default: begin
                     conf_in  = acc_ff[TB-1:0];
                     lph      = PH_CONF;
                     state_in = ST_OUT;
                  end
               endcase
               if (state_in == ST_MUL) begin
                  phase_in = lph;
                  acc_in   = l_acc;
                  mcand_in = l_mcand;
                  mq_in    = l_mq;
                  step_in  = l_steps;
               end
            end
         end
         ST_OUT: begin
            // hold until the response register is free
            if (!rv_ff || rsp_chan.ready) begin
               rv_in      = 1'b1;
               o_send_in  = sync_ff;
               o_wsync_in = sync_ff && !end_ff;
               o_echo_in  = sync_ff ? sync_time_ff : '0;
               o_delay_in = $signed({2'b00, now_ff}) - $signed({2'b00, sync_time_ff})
                            - {off_ff[OB-1], off_ff};
               o_rtt_in   = rtt_ff;
               o_dev_in   = dev_ff;
               o_event_in = !reported_ff && (count_ff >= init_cnt_ff);
               if (!reported_ff && (count_ff >= init_cnt_ff)) begin
                  reported_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_w_ff     <= RTT_WEIGHT_RST;
         dev_w_ff     <= DEV_WEIGHT_RST;
         init_cnt_ff  <= INIT_COUNT_RST;
         rtt_ff       <= '1;
         off_ff       <= '0;
         dev_ff       <= '0;
         conf_ff      <= {{(TB-CONF_BITS){1'b0}}, INIT_CONF_RST};
         seeded_ff    <= 1'b0;
         reported_ff  <= 1'b0;
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DEV;
         rv_ff        <= 1'b0;
      end else begin
         rtt_w_ff     <= rtt_w_in;
         dev_w_ff     <= dev_w_in;
         init_cnt_ff  <= init_cnt_in;
         rtt_ff       <= rtt_in;
         off_ff       <= off_in;
         dev_ff       <= dev_in;
         conf_ff      <= conf_in;
         seeded_ff    <= seeded_in;
         reported_ff  <= reported_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      sync_ff      <= sync_in;
      end_ff       <= end_in;
      reply_ff     <= reply_in;
      sync_time_ff <= sync_time_in;
      now_ff       <= now_in;
      s_ff         <= s_in;
      diff_ff      <= diff_in;
      nd_ff        <= nd_in;
      den_ff       <= den_in;
      divr_ff      <= divr_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mq_ff        <= mq_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      o_send_ff    <= o_send_in;
      o_wsync_ff   <= o_wsync_in;
      o_event_ff   <= o_event_in;
      o_echo_ff    <= o_echo_in;
      o_dev_ff     <= o_dev_in;
      o_delay_ff   <= o_delay_in;
      o_rtt_ff     <= o_rtt_in;
   end

   assign rsp_chan.valid           = rv_ff;
   assign rsp_chan.send_reply      = o_send_ff;
   assign rsp_chan.reply_with_sync = o_wsync_ff;
   assign rsp_chan.reply_echo_time = o_echo_ff;
   assign rsp_chan.arrival_delay   = o_delay_ff;
   assign rsp_chan.rtt_estimate    = o_rtt_ff;
   assign rsp_chan.rtt_deviation   = o_dev_ff;
   assign rsp_chan.connect_event   = o_event_ff;

endmodule

`default_nettype wire
